/* src/sleg_pkg.sv */
package sleg_pkg;

  localparam int unsigned TimeW   = 32;
  localparam int unsigned StatusW = 4;
  localparam int unsigned ColorW  = 8;
  localparam int unsigned IndexW  = 3;
  localparam int unsigned ChaseW  = 6;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  localparam logic OpTick      = 1'b0;
  localparam logic OpSetStatus = 1'b1;

  localparam logic [StatusW-1:0] StOff          = 4'd0;
  localparam logic [StatusW-1:0] StReady        = 4'd1;
  localparam logic [StatusW-1:0] StCreating     = 4'd2;
  localparam logic [StatusW-1:0] StRunning      = 4'd3;
  localparam logic [StatusW-1:0] StPausing      = 4'd4;
  localparam logic [StatusW-1:0] StResuming     = 4'd5;
  localparam logic [StatusW-1:0] StApproval     = 4'd6;
  localparam logic [StatusW-1:0] StWaiting      = 4'd7;
  localparam logic [StatusW-1:0] StPaused       = 4'd8;
  localparam logic [StatusW-1:0] StDone         = 4'd9;
  localparam logic [StatusW-1:0] StError        = 4'd10;

  localparam logic [TimeW-1:0] PeriodBreath   = 32'd30;
  localparam logic [TimeW-1:0] PeriodChase    = 32'd60;
  localparam logic [TimeW-1:0] PeriodApproval = 32'd400;
  localparam logic [TimeW-1:0] PeriodError    = 32'd180;

  // Paused double blink, phase within the 1600 ms period
  localparam logic [10:0] PauseOn1End   = 11'd120;
  localparam logic [10:0] PauseOn2Start = 11'd240;
  localparam logic [10:0] PauseOn2End   = 11'd360;

  typedef struct packed {
    logic                 operation;
    logic [TimeW-1:0]     now_ms;
    logic [StatusW-1:0]   status;
  } in_item_t;

  typedef struct packed {
    logic [IndexW-1:0]    led_index;
    logic [ColorW-1:0]    red;
    logic [ColorW-1:0]    green;
    logic [ColorW-1:0]    blue;
    logic                 last_led;
  } out_item_t;

  typedef struct packed {
    logic                 chase;
    logic [ChaseW-1:0]    lead;
    logic [ColorW-1:0]    red;
    logic [ColorW-1:0]    green;
    logic [ColorW-1:0]    blue;
  } frame_t;

  function automatic logic [7:0] tri_wave(logic [7:0] phase);
    return phase[7] ? {~phase[6:0], 1'b0} : {phase[6:0], 1'b0};
  endfunction

  // floor(x / 255), exact for x below 65280
  function automatic logic [7:0] div255(logic [15:0] x);
    logic [15:0] t;
    t = x + 16'd1 + {8'd0, x[15:8]};
    return t[15:8];
  endfunction

  function automatic logic [7:0] ready_level(logic [7:0] phase);
    logic [15:0] w;
    logic [15:0] prod;
    w    = {8'd0, tri_wave(phase)};
    prod = (w << 6) + (w << 5);
    return 8'd24 + div255(prod);
  endfunction

  function automatic logic [7:0] waiting_level(logic [7:0] phase);
    logic [15:0] w;
    logic [15:0] prod;
    w    = {8'd0, tri_wave(phase)};
    prod = (w << 6) + (w << 4) + (w << 1);
    return 8'd18 + div255(prod);
  endfunction

endpackage

/* src/sleg_front.sv */
module sleg_front import sleg_pkg::*; #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_item_i,
  output logic     frame_valid_o,
  input  logic     frame_ready_i,
  output frame_t   frame_o
);

  typedef struct packed {
    logic                 tick;
    logic                 clear;
    logic [StatusW-1:0]   status;
    logic [TimeW-1:0]     now;
    logic [7:0]           phase_r;
    logic [7:0]           phase_w;
    logic [11:0]          mod_sum;
    logic [5:0]           mod_low;
  } stage_t;

  localparam logic [ChaseW-1:0] ChaseLast = ChaseW'(LED_COUNT - 1);

  logic               a_valid_q;
  in_item_t           a_item_q;
  logic [StatusW-1:0] status_q;
  logic [TimeW-1:0]   start_q;

  logic               b_valid_q;
  stage_t             b_q;
  stage_t             b_d;
  logic [TimeW-1:0]   last_q, last_d;
  logic [ChaseW-1:0]  chase_q, chase_d;
  logic               blink_q, blink_d;

  logic               b_ready;
  logic               b_done;
  logic               a_move;
  logic               change;
  logic [TimeW-1:0]   elapsed;

  logic               emit;
  frame_t             frame;
  logic [TimeW-1:0]   since;
  logic               never;
  logic [10:0]        v;
  logic [21:0]        qprod;
  logic [5:0]         quot;
  logic [10:0]        rem;
  logic [10:0]        phase_p;
  logic               want;
  logic [ColorW-1:0]  lvl_r, lvl_w;

  assign in_ready_o = !a_valid_q || b_ready;
  assign a_move     = a_valid_q && b_ready;

  // Stage A: classify, own status and start time, reduce elapsed modulo 1600
  assign change  = (a_item_q.operation == OpSetStatus) && (a_item_q.status != status_q);
  assign elapsed = a_item_q.now_ms - start_q;

  always_comb begin
    b_d.tick    = (a_item_q.operation == OpTick);
    b_d.clear   = change;
    b_d.status  = status_q;
    b_d.now     = a_item_q.now_ms;
    b_d.phase_r = elapsed[10:3];
    b_d.phase_w = elapsed[11:4];
    // 1024 is -1 modulo 25; 1025 keeps the sum positive
    b_d.mod_sum = 12'({2'd0, elapsed[15:6]}) + 12'({6'd0, elapsed[31:26]}) + 12'd1025
                - 12'({2'd0, elapsed[25:16]});
    b_d.mod_low = elapsed[5:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      status_q  <= StOff;
      start_q   <= '0;
      last_q    <= '0;
      chase_q   <= '0;
      blink_q   <= 1'b0;
    end else begin
      if (in_ready_o) begin
        a_valid_q <= in_valid_i;
      end
      if (b_ready) begin
        b_valid_q <= a_valid_q;
      end
      if (a_move && change) begin
        status_q <= a_item_q.status;
        start_q  <= a_item_q.now_ms;
      end
      if (b_done) begin
        last_q  <= last_d;
        chase_q <= chase_d;
        blink_q <= blink_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      a_item_q <= in_item_i;
    end
    if (a_move) begin
      b_q <= b_d;
    end
  end

  // Stage B: finish the modulo, check timing, build the frame
  assign v     = 11'({1'b0, b_q.mod_sum[9:0]}) + 11'd25 - 11'({9'd0, b_q.mod_sum[11:10]});
  assign qprod = 22'(v) * 22'd2622;
  assign quot  = qprod[21:16];
  assign rem   = v - 11'(quot) * 11'd25;
  assign phase_p = {rem[4:0], b_q.mod_low};
  assign want  = (phase_p < PauseOn1End) ||
                 ((phase_p >= PauseOn2Start) && (phase_p < PauseOn2End));

  assign lvl_r = ready_level(b_q.phase_r);
  assign lvl_w = waiting_level(b_q.phase_w);

  assign since = b_q.now - last_q;
  assign never = (last_q == '0);

  always_comb begin
    emit        = 1'b0;
    frame.chase = 1'b0;
    frame.lead  = chase_q;
    frame.red   = '0;
    frame.green = '0;
    frame.blue  = '0;
    last_d      = last_q;
    chase_d     = chase_q;
    blink_d     = blink_q;
    if (b_q.clear) begin
      last_d  = '0;
      chase_d = '0;
      blink_d = 1'b0;
    end else if (b_q.tick) begin
      unique case (b_q.status)
        StReady: begin
          if (never || since >= PeriodBreath) begin
            emit        = 1'b1;
            last_d      = b_q.now;
            frame.green = lvl_r;
            frame.blue  = lvl_r + 8'd60;
          end
        end
        StWaiting: begin
          if (never || since >= PeriodBreath) begin
            emit        = 1'b1;
            last_d      = b_q.now;
            frame.red   = lvl_w;
            frame.blue  = lvl_w + 8'd80;
          end
        end
        StCreating, StRunning, StPausing, StResuming: begin
          if (never || since >= PeriodChase) begin
            emit        = 1'b1;
            last_d      = b_q.now;
            frame.chase = 1'b1;
            chase_d     = (chase_q == ChaseLast) ? '0 : chase_q + 1'b1;
          end
        end
        StApproval: begin
          if (never || since >= PeriodApproval) begin
            emit    = 1'b1;
            last_d  = b_q.now;
            blink_d = !blink_q;
            if (!blink_q) begin
              frame.red   = 8'd255;
              frame.green = 8'd100;
            end
          end
        end
        StError: begin
          if (never || since >= PeriodError) begin
            emit    = 1'b1;
            last_d  = b_q.now;
            blink_d = !blink_q;
            if (!blink_q) begin
              frame.red = 8'd255;
            end
          end
        end
        StPaused: begin
          if (never || want != blink_q) begin
            emit    = 1'b1;
            last_d  = b_q.now;
            blink_d = want;
            if (want) begin
              frame.red   = 8'd255;
              frame.green = 8'd160;
            end
          end
        end
        StDone: begin
          if (chase_q == '0) begin
            emit        = 1'b1;
            chase_d     = ChaseW'(1);
            frame.green = 8'd180;
            frame.blue  = 8'd40;
          end
        end
        default: begin
          emit = 1'b0;
        end
      endcase
    end
  end

  assign b_done        = b_valid_q && (!emit || frame_ready_i);
  assign b_ready       = !b_valid_q || b_done;
  assign frame_valid_o = b_valid_q && emit;
  assign frame_o       = frame;

endmodule

/* src/sleg_queue.sv */
module sleg_queue import sleg_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_valid_i,
  output logic   push_ready_o,
  input  frame_t push_data_i,
  output logic   pop_valid_o,
  input  logic   pop_ready_i,
  output frame_t pop_data_o
);

  frame_t                mem_q [QueueDepth];
  logic [QueuePtrW-1:0]  wr_q;
  logic [QueuePtrW-1:0]  rd_q;
  logic [QueueCntW-1:0]  cnt_q;
  logic                  push;
  logic                  pop;

  localparam logic [QueuePtrW-1:0] PtrLast = QueuePtrW'(QueueDepth - 1);

  assign push_ready_o = (cnt_q != QueueCntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign pop_data_o   = mem_q[rd_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PtrLast) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == PtrLast) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop && !push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

/* src/sleg_back.sv */
module sleg_back import sleg_pkg::*; #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      frame_valid_i,
  output logic      frame_ready_o,
  input  frame_t    frame_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  localparam int unsigned IW = $clog2(LED_COUNT);
  localparam logic [IW-1:0] LastIdx = IW'(LED_COUNT - 1);

  logic [IW-1:0] idx_q;
  logic          out_valid_q;
  out_item_t     out_q, out_d;
  logic          out_free;
  logic          load;
  logic [IW-1:0] lead;
  logic [IW-1:0] behind1;
  logic [IW-1:0] behind2;

  assign out_free      = !out_valid_q || out_ready_i;
  assign load          = frame_valid_i && out_free;
  assign frame_ready_o = load && (idx_q == LastIdx);

  assign lead    = frame_i.lead[IW-1:0];
  assign behind1 = (lead == '0) ? LastIdx : lead - 1'b1;
  assign behind2 = (behind1 == '0) ? LastIdx : behind1 - 1'b1;

  always_comb begin
    out_d.led_index = IndexW'(idx_q);
    out_d.last_led  = (idx_q == LastIdx);
    out_d.red       = frame_i.red;
    out_d.green     = frame_i.green;
    out_d.blue      = frame_i.blue;
    if (frame_i.chase) begin
      priority if (idx_q == lead) begin
        out_d.red   = 8'd30;
        out_d.green = 8'd120;
        out_d.blue  = 8'd255;
      end else if (idx_q == behind1) begin
        out_d.red   = 8'd0;
        out_d.green = 8'd45;
        out_d.blue  = 8'd120;
      end else if (idx_q == behind2) begin
        out_d.red   = 8'd0;
        out_d.green = 8'd15;
        out_d.blue  = 8'd45;
      end else begin
        out_d.red   = 8'd0;
        out_d.green = 8'd0;
        out_d.blue  = 8'd0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid_q <= frame_valid_i;
      end
      if (load) begin
        idx_q <= (idx_q == LastIdx) ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

/* src/status_led_effect_generator.sv */
// Status LED effect generator for a ring of LED_COUNT RGB LEDs. Set-status and
// tick items enter at up to one per cycle; a two-stage front checks timing and
// keeps the effect state, and hands each due frame through a two-entry queue
// to the output sequencer, which sends LED_COUNT color items, one per cycle
// while the consumer is ready, with last_led on the final one. A tick that
// produces a frame thus yields LED_COUNT output items; ticks that produce
// nothing and set-status items yield none. A tick's first color item passes
// stage A, stage B, the queue and the output register, in that order.
module status_led_effect_generator import sleg_pkg::*; #(
  parameter int unsigned LED_COUNT = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  logic   fq_valid;
  logic   fq_ready;
  frame_t fq_data;
  logic   qb_valid;
  logic   qb_ready;
  frame_t qb_data;

  sleg_front #(
    .LED_COUNT(LED_COUNT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item_i),
    .frame_valid_o(fq_valid),
    .frame_ready_i(fq_ready),
    .frame_o      (fq_data)
  );

  sleg_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fq_valid),
    .push_ready_o(fq_ready),
    .push_data_i (fq_data),
    .pop_valid_o (qb_valid),
    .pop_ready_i (qb_ready),
    .pop_data_o  (qb_data)
  );

  sleg_back #(
    .LED_COUNT(LED_COUNT)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .frame_valid_i(qb_valid),
    .frame_ready_o(qb_ready),
    .frame_i      (qb_data),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_item_o   (out_item_o)
  );

endmodule

/* test/tb_top.sv */
module tb_top;
  import sleg_pkg::*;

  localparam int RingLeds = 8;
  localparam int Predicted = -1;
  localparam logic [StatusW-1:0] StUnknownTop = 4'd15;
  localparam int DrainCycles = 12;

  typedef struct {
    in_item_t   item;
    int         led_n;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } stim_row_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_item_t out_item_o;

  logic [StatusW-1:0] cur_status = StOff;
  logic [31:0]        start_ms = '0;
  logic [31:0]        last_ms = '0;
  logic [5:0]         chase_pos = '0;
  logic               blink = 1'b0;

  out_item_t frame_leds [RingLeds];
  int        frame_len;
  out_item_t led_expect [$];
  stim_row_t live_row;
  int        err_count = 0;
  bit        calm = 1'b0;
  int        stall_left = 0;

  status_led_effect_generator u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  always #5 clk_i = ~clk_i;

  task automatic report_mismatch(string what, longint got, longint want);
    $display("tb_top: mismatch on %s at %0t: got %0d, want %0d", what, $time, got, want);
    err_count++;
  endtask

  function automatic bit is_due(logic [31:0] now, logic [31:0] period);
    logic [31:0] gap;
    gap = now - last_ms;
    return (last_ms == 32'd0) || (gap >= period);
  endfunction

  function automatic int breath_wave(logic [7:0] phase);
    int p;
    p = int'(phase);
    return (p < 128) ? 2 * p : 2 * (255 - p);
  endfunction

  task automatic fill_ring(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    for (int i = 0; i < RingLeds; i++) begin
      frame_leds[i] = '{led_index: i[2:0], red: r, green: g, blue: b,
                        last_led: (i == RingLeds - 1)};
    end
    frame_len = RingLeds;
  endtask

  task automatic paint_led(logic [2:0] idx, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    frame_leds[idx].red   = r;
    frame_leds[idx].green = g;
    frame_leds[idx].blue  = b;
  endtask

  task automatic advance_effect(in_item_t it);
    logic [31:0] elapsed;
    logic [31:0] phase;
    logic [2:0]  lead;
    logic [7:0]  lvl;
    bit          want;
    elapsed = it.now_ms - start_ms;
    frame_len = 0;
    if (it.operation == OpSetStatus) begin
      if (it.status != cur_status) begin
        cur_status = it.status;
        start_ms   = it.now_ms;
        last_ms    = '0;
        chase_pos  = '0;
        blink      = 1'b0;
      end
    end else begin
      case (cur_status)
        StReady, StWaiting: begin
          if (is_due(it.now_ms, PeriodBreath)) begin
            last_ms = it.now_ms;
            if (cur_status == StReady) begin
              lvl = 8'(24 + breath_wave(elapsed[10:3]) * 96 / 255);
              fill_ring(8'd0, lvl, lvl + 8'd60);
            end else begin
              lvl = 8'(18 + breath_wave(elapsed[11:4]) * 82 / 255);
              fill_ring(lvl, 8'd0, lvl + 8'd80);
            end
          end
        end
        StCreating, StRunning, StPausing, StResuming: begin
          if (is_due(it.now_ms, PeriodChase)) begin
            last_ms = it.now_ms;
            lead = chase_pos[2:0];
            fill_ring(8'd0, 8'd0, 8'd0);
            paint_led(lead, 8'd30, 8'd120, 8'd255);
            paint_led(lead - 3'd1, 8'd0, 8'd45, 8'd120);
            paint_led(lead - 3'd2, 8'd0, 8'd15, 8'd45);
            chase_pos = {3'd0, lead + 3'd1};
          end
        end
        StApproval, StError: begin
          if (is_due(it.now_ms, (cur_status == StApproval) ? PeriodApproval : PeriodError))
          begin
            last_ms = it.now_ms;
            blink = ~blink;
            if (!blink) begin
              fill_ring(8'd0, 8'd0, 8'd0);
            end else if (cur_status == StApproval) begin
              fill_ring(8'd255, 8'd100, 8'd0);
            end else begin
              fill_ring(8'd255, 8'd0, 8'd0);
            end
          end
        end
        StPaused: begin
          phase = elapsed % 32'd1600;
          want = (phase < 32'(PauseOn1End)) ||
                 (phase >= 32'(PauseOn2Start) && phase < 32'(PauseOn2End));
          if (last_ms == 32'd0 || want != blink) begin
            last_ms = it.now_ms;
            blink = want;
            if (want) begin
              fill_ring(8'd255, 8'd160, 8'd0);
            end else begin
              fill_ring(8'd0, 8'd0, 8'd0);
            end
          end
        end
        StDone: begin
          if (chase_pos == 6'd0) begin
            chase_pos = 6'd1;
            fill_ring(8'd0, 8'd180, 8'd40);
          end
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        advance_effect(in_item_i);
        if (live_row.led_n == Predicted) begin
          for (int i = 0; i < frame_len; i++) led_expect.push_back(frame_leds[i]);
        end else begin
          for (int i = 0; i < live_row.led_n; i++) begin
            led_expect.push_back('{led_index: i[2:0], red: live_row.red,
                                   green: live_row.green, blue: live_row.blue,
                                   last_led: (i == RingLeds - 1)});
          end
        end
      end
      if (out_valid_o && out_ready_i) begin
        if (led_expect.size() == 0) begin
          report_mismatch("unexpected led item", out_item_o.led_index, -1);
        end else begin
          out_item_t want;
          want = led_expect.pop_front();
          if (out_item_o.led_index != want.led_index)
            report_mismatch("led_index", out_item_o.led_index, want.led_index);
          if (out_item_o.red != want.red)
            report_mismatch("red", out_item_o.red, want.red);
          if (out_item_o.green != want.green)
            report_mismatch("green", out_item_o.green, want.green);
          if (out_item_o.blue != want.blue)
            report_mismatch("blue", out_item_o.blue, want.blue);
          if (out_item_o.last_led != want.last_led)
            report_mismatch("last_led", out_item_o.last_led, want.last_led);
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (!calm && $urandom_range(0, 99) < 20) begin
      out_ready_i <= 1'b0;
      stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 2) : $urandom_range(9, 39);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  function automatic stim_row_t mk_row(logic op, logic [31:0] now, logic [StatusW-1:0] st,
                                       int n, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    stim_row_t row;
    row.item  = '{operation: op, now_ms: now, status: st};
    row.led_n = n;
    row.red   = r;
    row.green = g;
    row.blue  = b;
    return row;
  endfunction

  function automatic int send_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_item(stim_row_t row);
    int gap;
    gap = send_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    live_row = row;
    in_valid_i <= 1'b1;
    in_item_i <= row.item;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (led_expect.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  initial begin
    stim_row_t          directed_rows [$];
    int                 sent;
    int                 ticks;
    int                 r;
    logic [31:0]        now;
    logic [StatusW-1:0] st;
    bit                 pressed;
    live_row = mk_row(OpTick, '0, StOff, 0, 8'd0, 8'd0, 8'd0);
    directed_rows = '{
      mk_row(OpTick,      32'd0,          StOff,        0,         8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'hFFFFFFFF,   StDone,       0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd0,          StOff,        RingLeds,  8'd0,   8'd180, 8'd40),
      mk_row(OpTick,      32'd5,          StOff,        0,         8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'd100,        StError,      0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd100,        StOff,        RingLeds,  8'd255, 8'd0,   8'd0),
      mk_row(OpTick,      32'd279,        StOff,        0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd280,        StOff,        RingLeds,  8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'd1000,       StApproval,   0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd1000,       StOff,        RingLeds,  8'd255, 8'd100, 8'd0),
      mk_row(OpSetStatus, 32'd1200,       StApproval,   0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd1400,       StOff,        RingLeds,  8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'd5000,       StPaused,     0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd5119,       StOff,        RingLeds,  8'd255, 8'd160, 8'd0),
      mk_row(OpTick,      32'd5120,       StOff,        RingLeds,  8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'hFFFFFFF0,   StReady,      0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'hFFFFFFF0,   StOff,        Predicted, 8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'h0000000E,   StOff,        Predicted, 8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'hFFFFFF00,   StWaiting,    0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd0,          StOff,        Predicted, 8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd1,          StOff,        Predicted, 8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'd50,         StCreating,   0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd109,        StOff,        Predicted, 8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd169,        StOff,        Predicted, 8'd0,   8'd0,   8'd0),
      mk_row(OpSetStatus, 32'd9,          StUnknownTop, 0,         8'd0,   8'd0,   8'd0),
      mk_row(OpTick,      32'd4000,       StOff,        0,         8'd0,   8'd0,   8'd0)
    };
    repeat (2) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_item(directed_rows[i]);

    sent = 0;
    pressed = 1'b0;
    while (sent < 104) begin
      calm = (sent >= 30 && sent < 60);
      if (!pressed && sent >= 70) begin
        drain_results();
        pressed = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 85) begin
        st = 4'($urandom_range(32'(StReady), 32'(StError)));
      end else if (r < 90) begin
        st = StOff;
      end else begin
        st = 4'($urandom_range(32'(StError) + 1, 32'(StUnknownTop)));
      end
      now = ($urandom_range(0, 9) == 0) ? 32'hFFFFFFFF - $urandom_range(0, 400) : $urandom;
      send_item(mk_row(OpSetStatus, now, st, Predicted, 8'd0, 8'd0, 8'd0));
      sent++;
      ticks = $urandom_range(2, 9);
      repeat (ticks) begin
        r = $urandom_range(0, 99);
        if (r < 60) now += $urandom_range(20, 130);
        else if (r < 85) now += $urandom_range(0, 30);
        else if (r < 95) now += $urandom_range(100, 700);
        else now = $urandom;
        if ($urandom_range(0, 19) == 0) begin
          send_item(mk_row(OpSetStatus, now, st, Predicted, 8'd0, 8'd0, 8'd0));
        end else begin
          send_item(mk_row(OpTick, now, 4'($urandom_range(0, 15)), Predicted,
                           8'd0, 8'd0, 8'd0));
        end
        sent++;
      end
    end
    calm = 1'b0;

    drain_results();
    if (err_count == 0 && led_expect.size() == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

endmodule

/* files.f */
src/sleg_pkg.sv
src/sleg_front.sv
src/sleg_queue.sv
src/sleg_back.sv
src/status_led_effect_generator.sv
test/tb_top.sv
